// ===== rtl/mrof_pkg.sv =====
// Shared types, sizes and codes of the multi-ring overwrite FIFO.
package mrof_pkg;

  localparam int NUM_RINGS   = 4;
  localparam int RING_DEPTH  = 256;
  localparam int DATA_WIDTH  = 8;

  localparam int LEN_REGS    = 4;
  localparam int ENABLE_BITS = 4;

  localparam int OP_W        = 1;
  localparam int RING_IDX_W  = 2;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int LEN_W       = 9;
  localparam int CFG_IDX_W   = 3;

  localparam int PTR_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_EFF_W   = PTR_W + 1;
  localparam int LREG_W      = (LEN_W > LEN_EFF_W) ? LEN_W : LEN_EFF_W;
  localparam int ADDR_W      = $clog2(NUM_RINGS * RING_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_DISABLED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_LEN_0  = 3'd1,
    REG_LEN_1  = 3'd2,
    REG_LEN_2  = 3'd3,
    REG_LEN_3  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                  operation;
    logic [RING_IDX_W-1:0] ring_index;
    logic [BYTE_W-1:0]     write_data;
  } item_t;

  typedef struct packed {
    logic [NUM_RINGS-1:0]                enable;
    logic [NUM_RINGS-1:0]                clear;
    logic [NUM_RINGS-1:0][LEN_EFF_W-1:0] eff_len;
  } cfg_state_t;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic                  rd_hit;
    logic [ADDR_W-1:0]     rd_addr;
  } store_req_t;

endpackage

// ===== rtl/mrof_in_if.sv =====
// Request channel: one access (push or pop) per beat.
interface mrof_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [mrof_pkg::RING_IDX_W-1:0]   ring_index;
  logic [mrof_pkg::BYTE_W-1:0]       write_data;

  modport source (output valid, output operation, output ring_index, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input ring_index, input write_data,
                  output ready);
endinterface

// ===== rtl/mrof_out_if.sv =====
// Result channel: status and popped byte, one beat per access.
interface mrof_out_if;
  logic                          valid;
  logic                          ready;
  logic [mrof_pkg::STATUS_W-1:0] status;
  logic [mrof_pkg::BYTE_W-1:0]   read_data;

  modport source (output valid, output status, output read_data, input ready);
  modport sink   (input valid, input status, input read_data, output ready);
endinterface

// ===== rtl/mrof_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface mrof_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mrof_pkg::CFG_IDX_W-1:0] index;
  logic [mrof_pkg::LEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mrof_regs.sv =====
// Configuration registers: enable mask, ring lengths and ring clear requests.
module mrof_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  mrof_cfg_if.sink              cfg_ch,
  output mrof_pkg::cfg_state_t  cfg_state
);

  logic [mrof_pkg::ENABLE_BITS-1:0]                    en_r;
  logic [mrof_pkg::ENABLE_BITS-1:0]                    en_nxt;
  logic [mrof_pkg::LEN_REGS-1:0][mrof_pkg::LREG_W-1:0] len_r;
  logic [mrof_pkg::LEN_REGS-1:0][mrof_pkg::LREG_W-1:0] len_nxt;
  logic                                                wr;
  logic [mrof_pkg::NUM_RINGS-1:0]                      clear_req;

  // A length of zero behaves as one slot; anything beyond the ring depth as the depth.
  function automatic logic [mrof_pkg::LEN_EFF_W-1:0] clamp_len(
    input logic [mrof_pkg::LREG_W-1:0] len);
    logic [mrof_pkg::LEN_EFF_W-1:0] res;
    if (len == '0) begin
      res = mrof_pkg::LEN_EFF_W'(1);
    end else if (32'(len) > 32'(mrof_pkg::RING_DEPTH)) begin
      res = mrof_pkg::LEN_EFF_W'(mrof_pkg::RING_DEPTH);
    end else begin
      res = mrof_pkg::LEN_EFF_W'(len);
    end
    return res;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  always_comb begin
    en_nxt  = en_r;
    len_nxt = len_r;
    if (wr && cfg_ch.index == mrof_pkg::REG_ENABLE) begin
      en_nxt = cfg_ch.data[mrof_pkg::ENABLE_BITS-1:0];
    end
    for (int i = 0; i < mrof_pkg::LEN_REGS; i++) begin
      if (wr && cfg_ch.index == mrof_pkg::CFG_IDX_W'(int'(mrof_pkg::REG_LEN_0) + i)) begin
        len_nxt[i] = mrof_pkg::LREG_W'(cfg_ch.data);
      end
    end
  end

  // Clear a ring when its enable bit rises or its length is written.
  always_comb begin
    clear_req = '0;
    for (int r = 0; r < mrof_pkg::NUM_RINGS; r++) begin
      if (r < mrof_pkg::ENABLE_BITS) begin
        if (wr && cfg_ch.index == mrof_pkg::REG_ENABLE &&
            cfg_ch.data[r] && !en_r[2'(r)]) begin
          clear_req[r] = 1'b1;
        end
      end
      if (r < mrof_pkg::LEN_REGS) begin
        if (wr && cfg_ch.index == mrof_pkg::CFG_IDX_W'(int'(mrof_pkg::REG_LEN_0) + r)) begin
          clear_req[r] = 1'b1;
        end
      end
    end
  end

  assign cfg_state.clear = clear_req;

  for (genvar r = 0; r < mrof_pkg::NUM_RINGS; r++) begin : g_ring
    if (r < mrof_pkg::ENABLE_BITS) begin : g_en
      assign cfg_state.enable[r] = en_r[r];
    end else begin : g_no_en
      assign cfg_state.enable[r] = 1'b0;
    end
    if (r < mrof_pkg::LEN_REGS) begin : g_len
      assign cfg_state.eff_len[r] = clamp_len(len_r[r]);
    end else begin : g_no_len
      assign cfg_state.eff_len[r] = mrof_pkg::LEN_EFF_W'(mrof_pkg::RING_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= '0;
      len_r <= {mrof_pkg::LEN_REGS{mrof_pkg::LREG_W'(mrof_pkg::RING_DEPTH)}};
    end else begin
      en_r  <= en_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

// ===== rtl/mrof_ring_ctrl.sv =====
// Ring pointer state and the per-access push/pop decision.
module mrof_ring_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  mrof_pkg::item_t       item,
  input  mrof_pkg::cfg_state_t  cfg_state,
  output mrof_pkg::store_req_t  store_req,
  output mrof_pkg::status_t     status
);

  logic [mrof_pkg::NUM_RINGS-1:0][mrof_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [mrof_pkg::NUM_RINGS-1:0][mrof_pkg::PTR_W-1:0] rp_r, rp_nxt;
  logic [mrof_pkg::NUM_RINGS-1:0]                      full_r, full_nxt;

  logic                           sel_on;
  logic [mrof_pkg::PTR_W-1:0]     sel_wp;
  logic [mrof_pkg::PTR_W-1:0]     sel_rp;
  logic                           sel_full;
  logic [mrof_pkg::LEN_EFF_W-1:0] sel_len;
  logic [mrof_pkg::PTR_W-1:0]     wp_adv;
  logic [mrof_pkg::PTR_W-1:0]     rp_adv;
  logic                           is_pop;
  logic                           not_empty;

  function automatic logic [mrof_pkg::PTR_W-1:0] step_ptr(
    input logic [mrof_pkg::PTR_W-1:0]     ptr,
    input logic [mrof_pkg::LEN_EFF_W-1:0] len);
    logic [mrof_pkg::PTR_W:0] inc;
    inc = {1'b0, ptr} + 1'b1;
    return (inc >= len) ? '0 : inc[mrof_pkg::PTR_W-1:0];
  endfunction

  function automatic logic [mrof_pkg::ADDR_W-1:0] slot_addr(
    input logic [mrof_pkg::RING_IDX_W-1:0] ring,
    input logic [mrof_pkg::PTR_W-1:0]      ptr);
    return mrof_pkg::ADDR_W'(int'(ring) * mrof_pkg::RING_DEPTH + int'(ptr));
  endfunction

  // Select the addressed ring; an index past the last ring reads as disabled.
  always_comb begin
    sel_on   = 1'b0;
    sel_wp   = '0;
    sel_rp   = '0;
    sel_full = 1'b0;
    sel_len  = mrof_pkg::LEN_EFF_W'(1);
    for (int i = 0; i < mrof_pkg::NUM_RINGS; i++) begin
      if (int'(item.ring_index) == i) begin
        sel_on   = cfg_state.enable[i];
        sel_wp   = wp_r[i];
        sel_rp   = rp_r[i];
        sel_full = full_r[i];
        sel_len  = cfg_state.eff_len[i];
      end
    end
  end

  assign is_pop    = (item.operation == mrof_pkg::OP_POP);
  assign not_empty = (sel_wp != sel_rp) || sel_full;
  assign wp_adv    = step_ptr(sel_wp, sel_len);
  assign rp_adv    = step_ptr(sel_rp, sel_len);

  always_comb begin
    if (!sel_on) begin
      status = mrof_pkg::STATUS_DISABLED;
    end else if (is_pop && !not_empty) begin
      status = mrof_pkg::STATUS_EMPTY;
    end else begin
      status = mrof_pkg::STATUS_DONE;
    end
  end

  always_comb begin
    store_req.wr_en   = go && sel_on && !is_pop;
    store_req.wr_addr = slot_addr(item.ring_index, sel_wp);
    store_req.wr_data = mrof_pkg::DATA_WIDTH'(item.write_data);
    store_req.rd_en   = go;
    store_req.rd_hit  = sel_on && is_pop && not_empty;
    store_req.rd_addr = slot_addr(item.ring_index, sel_rp);
  end

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    full_nxt = full_r;
    for (int i = 0; i < mrof_pkg::NUM_RINGS; i++) begin
      if (go && sel_on && int'(item.ring_index) == i) begin
        if (!is_pop) begin
          wp_nxt[i] = wp_adv;
          if (!sel_full) begin
            full_nxt[i] = (wp_adv == sel_rp);
          end else begin
            // Full ring: the oldest byte is overwritten, so the read side follows.
            rp_nxt[i] = wp_adv;
          end
        end else if (not_empty) begin
          rp_nxt[i]   = rp_adv;
          full_nxt[i] = 1'b0;
        end
      end
      if (cfg_state.clear[i]) begin
        wp_nxt[i]   = '0;
        rp_nxt[i]   = '0;
        full_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      full_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      full_r <= full_nxt;
    end
  end

endmodule

// ===== rtl/mrof_store.sv =====
// Shared byte store of all rings with a registered read port.
module mrof_store (
  input  logic                  clk,
  input  mrof_pkg::store_req_t  store_req,
  output logic [mrof_pkg::BYTE_W-1:0] rd_data
);

  logic [mrof_pkg::DATA_WIDTH-1:0] mem [mrof_pkg::NUM_RINGS * mrof_pkg::RING_DEPTH];
  logic [mrof_pkg::BYTE_W-1:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (store_req.wr_en) begin
      mem[store_req.wr_addr] <= store_req.wr_data;
    end
  end

  // Only a successful pop returns stored data; every other result carries zero.
  always_ff @(posedge clk) begin
    if (store_req.rd_en) begin
      rd_data_r <= store_req.rd_hit ? mrof_pkg::BYTE_W'(mem[store_req.rd_addr]) : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/multi_ring_overwrite_fifo_core.sv =====
// An accepted request beat waits in the request register and moves into the result
//   register once that is empty or being emptied; the result beat is taken from there.
// Throughput: one request per cycle, sustained while results are taken; one pass through the
//   ring pointers and one port of the shared byte store per cycle set that figure.
// Reset (rst_n, synchronous, active low): all rings disabled, pointers and full flags
//   cleared, lengths at full depth. The byte store is not cleared and needs no pass.
// Configuration writes are taken on every cycle while the block is idle.
module multi_ring_overwrite_fifo_core (
  input  logic       clk,
  input  logic       rst_n,
  mrof_in_if.sink    in_ch,
  mrof_out_if.source out_ch,
  mrof_cfg_if.sink   cfg_ch
);

  // Request register: holds one accepted beat until the result stage can take it.
  logic                 in_v_r, in_v_nxt;
  mrof_pkg::item_t      item_r;
  // Result register: status here, the popped byte in the store's read register.
  logic                 out_v_r, out_v_nxt;
  mrof_pkg::status_t    status_r;

  logic                 in_fire;
  logic                 advance;
  mrof_pkg::cfg_state_t cfg_state;
  mrof_pkg::store_req_t store_req;
  mrof_pkg::status_t    status_c;
  logic [mrof_pkg::BYTE_W-1:0] rd_data;

  // The request moves on when the result register is empty or is being emptied, so
  // the request register refills in the same cycle and beats flow back to back.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.operation  <= in_ch.operation;
      item_r.ring_index <= in_ch.ring_index;
      item_r.write_data <= in_ch.write_data;
    end
    if (advance) begin
      status_r <= status_c;
    end
  end

  mrof_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .cfg_state (cfg_state)
  );

  // Pointers update at the edge where the request moves into the result register;
  // the next request therefore sees them already advanced.
  mrof_ring_ctrl u_ring_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .item      (item_r),
    .cfg_state (cfg_state),
    .store_req (store_req),
    .status    (status_c)
  );

  // A push writes at the same edge; a pop of that slot by the next request reads it back.
  mrof_store u_store (
    .clk       (clk),
    .store_req (store_req),
    .rd_data   (rd_data)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = status_r;
  assign out_ch.read_data = rd_data;

  // A full result register that is not drained must hold off the request stage.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_ch.ready) |-> (!in_ch.ready && !advance))
    else $error("request stage advanced into a stalled result register");

  // Every request that moves on shows up as a valid result in the next cycle.
  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("advanced request produced no result beat");

  // Rejected and empty accesses never carry a byte.
  a_no_data_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (status_r == mrof_pkg::STATUS_DISABLED ||
                 status_r == mrof_pkg::STATUS_EMPTY)) |-> (rd_data == '0))
    else $error("non-zero read data on a failed access");

  // A stalled result beat keeps its byte until it is taken.
  a_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> $stable(rd_data))
    else $error("read data changed while the result beat was stalled");

endmodule
